[rtl/core/gimb_pkg.sv]
`timescale 1ns / 1ps
// gimb_pkg: widths, fixed point constants, register codes and shared types of the gimbal controller
package gimb_pkg;

  // Q format of every internal value
  localparam int FRAC_BITS = 16;

  // port field widths
  localparam int ACCEL_W    = 25;
  localparam int GYRO_W     = 28;
  localparam int TARGET_W   = 24;
  localparam int GAIN_W     = 23;
  localparam int PULSE_W    = 12;
  localparam int DRIVE_W    = 23;
  localparam int FUSED_W    = 25;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // datapath widths
  localparam int WORD_W  = 32;
  localparam int SUM_W   = WORD_W + 2;
  localparam int MUL_B_W = 30;
  localparam int PROD_W  = WORD_W + MUL_B_W;

  // gyro scale 1/131 by reciprocal multiply, exact for magnitudes below 2^GYRO_W
  localparam int     GYRO_SCALE  = 131;
  localparam int     RECIP_SHIFT = GYRO_W + $clog2(GYRO_SCALE);
  localparam longint RECIP_M     = ((longint'(1) << RECIP_SHIFT) + GYRO_SCALE - 1) / GYRO_SCALE;
  localparam int     RATE_W      = GYRO_W - $clog2(GYRO_SCALE) + 2;
  localparam int     ROUND_BIAS  = GYRO_SCALE / 2;

  // accel minus offset (offsets stay below 8.0)
  localparam int AOFS_W = ((ACCEL_W > FRAC_BITS + 4) ? ACCEL_W : FRAC_BITS + 4) + 1;

  localparam int SERVO_W = PULSE_W + FRAC_BITS;
  localparam int DRV_W   = FRAC_BITS + 7;

  // filter coefficients, rounded to nearest
  localparam logic signed [MUL_B_W-1:0] K_095 =
    MUL_B_W'(((longint'(95) << FRAC_BITS) + 50) / 100);
  localparam logic signed [MUL_B_W-1:0] K_005 =
    MUL_B_W'(((longint'(5) << FRAC_BITS) + 50) / 100);
  localparam logic signed [MUL_B_W-1:0] K_002 =
    MUL_B_W'(((longint'(2) << FRAC_BITS) + 50) / 100);
  localparam logic signed [MUL_B_W-1:0] K_090 =
    MUL_B_W'(((longint'(90) << FRAC_BITS) + 50) / 100);
  localparam logic signed [MUL_B_W-1:0] K_010 =
    MUL_B_W'(((longint'(10) << FRAC_BITS) + 50) / 100);
  localparam logic signed [MUL_B_W-1:0] K_RECIP = MUL_B_W'(RECIP_M);

  localparam logic signed [AOFS_W-1:0] K_ROLL_OFS =
    AOFS_W'(((longint'(73) << FRAC_BITS) + 5) / 10);
  localparam logic signed [AOFS_W-1:0] K_PITCH_OFS =
    AOFS_W'(((longint'(9) << FRAC_BITS) + 5) / 10);

  localparam logic signed [WORD_W-1:0] K_DEADBAND =
    WORD_W'(((longint'(2) << FRAC_BITS) + 5) / 10);

  // limits
  localparam longint SAT_MAX_L = 64'sd2147483647;
  localparam longint SAT_MIN_L = -64'sd2147483648;
  localparam longint FUSED_L   = longint'(180) << FRAC_BITS;
  localparam logic signed [WORD_W-1:0] SAT_MAX = WORD_W'(SAT_MAX_L);
  localparam logic signed [WORD_W-1:0] SAT_MIN = WORD_W'(SAT_MIN_L);
  localparam logic signed [WORD_W-1:0] LIM_FUSED_HI =
    WORD_W'((FUSED_L > SAT_MAX_L) ? SAT_MAX_L : FUSED_L);
  localparam logic signed [WORD_W-1:0] LIM_FUSED_LO =
    WORD_W'((-FUSED_L < SAT_MIN_L) ? SAT_MIN_L : -FUSED_L);
  localparam logic signed [WORD_W-1:0] LIM_ANGLE_I = WORD_W'(longint'(50) << FRAC_BITS);
  localparam logic signed [WORD_W-1:0] LIM_RATE_I  = WORD_W'(longint'(30) << FRAC_BITS);
  localparam logic signed [WORD_W-1:0] LIM_DRIVE   = WORD_W'(longint'(50) << FRAC_BITS);

  localparam logic [SERVO_W-1:0] SERVO_MID = SERVO_W'(longint'(1500) << FRAC_BITS);
  localparam logic [SERVO_W-1:0] SERVO_MIN = SERVO_W'(longint'(500) << FRAC_BITS);
  localparam logic [SERVO_W-1:0] SERVO_MAX = SERVO_W'(longint'(2500) << FRAC_BITS);
  localparam logic [PULSE_W-1:0] PULSE_MIN = PULSE_W'(500);
  localparam logic [PULSE_W-1:0] PULSE_MAX = PULSE_W'(2500);

  // gain reset values: 2.3, 0.2, 0.005
  localparam logic [GAIN_W-1:0] RST_ANGLE_GAIN_P =
    GAIN_W'(((longint'(23) << FRAC_BITS) + 5) / 10);
  localparam logic [GAIN_W-1:0] RST_RATE_GAIN_P =
    GAIN_W'(((longint'(2) << FRAC_BITS) + 5) / 10);
  localparam logic [GAIN_W-1:0] RST_RATE_GAIN_D =
    GAIN_W'(((longint'(5) << FRAC_BITS) + 500) / 1000);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_TARGET  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_TARGET = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN_P = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN_I = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN_P  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN_I  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN_D  = CFG_IDX_W'(6);

  typedef struct packed {
    logic signed [TARGET_W-1:0] roll_target;
    logic signed [TARGET_W-1:0] pitch_target;
    logic [GAIN_W-1:0]          angle_gain_p;
    logic [GAIN_W-1:0]          angle_gain_i_step;
    logic [GAIN_W-1:0]          rate_gain_p;
    logic [GAIN_W-1:0]          rate_gain_i_step;
    logic [GAIN_W-1:0]          rate_gain_d_step;
  } cfg_regs_t;

  // one request to the shared multiplier
  typedef struct packed {
    logic                       recip;
    logic signed [WORD_W-1:0]   a;
    logic signed [MUL_B_W-1:0]  b;
  } mul_req_t;

endpackage

[rtl/core/gimb_if.sv]
`timescale 1ns / 1ps
// gimb_if: handshake channels of the gimbal controller (sensor word, result word, register writes)
interface gimb_in_if;
  import gimb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [ACCEL_W-1:0] accel_roll_angle;
  logic signed [ACCEL_W-1:0] accel_pitch_angle;
  logic signed [GYRO_W-1:0]  gyro_roll_rate;
  logic signed [GYRO_W-1:0]  gyro_pitch_rate;
  modport source (output valid, accel_roll_angle, accel_pitch_angle, gyro_roll_rate,
                  gyro_pitch_rate, input ready);
  modport sink (input valid, accel_roll_angle, accel_pitch_angle, gyro_roll_rate,
                gyro_pitch_rate, output ready);
endinterface

interface gimb_out_if;
  import gimb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [PULSE_W-1:0]        roll_pulse_us;
  logic [PULSE_W-1:0]        pitch_pulse_us;
  logic signed [DRIVE_W-1:0] roll_drive;
  logic signed [DRIVE_W-1:0] pitch_drive;
  logic signed [FUSED_W-1:0] roll_fused_angle;
  logic signed [FUSED_W-1:0] pitch_fused_angle;
  modport source (output valid, roll_pulse_us, pitch_pulse_us, roll_drive, pitch_drive,
                  roll_fused_angle, pitch_fused_angle, input ready);
  modport sink (input valid, roll_pulse_us, pitch_pulse_us, roll_drive, pitch_drive,
                roll_fused_angle, pitch_fused_angle, output ready);
endinterface

interface gimb_cfg_if;
  import gimb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/gimb_cfg_regs.sv]
`timescale 1ns / 1ps
// gimb_cfg_regs: setpoint and gain registers, written through the register channel
module gimb_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  gimb_cfg_if.sink            cfg,
  output gimb_pkg::cfg_regs_t regs
);
  import gimb_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.roll_target       <= '0;
      regs.pitch_target      <= '0;
      regs.angle_gain_p      <= RST_ANGLE_GAIN_P;
      regs.angle_gain_i_step <= '0;
      regs.rate_gain_p       <= RST_RATE_GAIN_P;
      regs.rate_gain_i_step  <= '0;
      regs.rate_gain_d_step  <= RST_RATE_GAIN_D;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_ROLL_TARGET:  regs.roll_target       <= TARGET_W'(cfg.data);
        REG_PITCH_TARGET: regs.pitch_target      <= TARGET_W'(cfg.data);
        REG_ANGLE_GAIN_P: regs.angle_gain_p      <= cfg.data[GAIN_W-1:0];
        REG_ANGLE_GAIN_I: regs.angle_gain_i_step <= cfg.data[GAIN_W-1:0];
        REG_RATE_GAIN_P:  regs.rate_gain_p       <= cfg.data[GAIN_W-1:0];
        REG_RATE_GAIN_I:  regs.rate_gain_i_step  <= cfg.data[GAIN_W-1:0];
        REG_RATE_GAIN_D:  regs.rate_gain_d_step  <= cfg.data[GAIN_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

endmodule

[rtl/core/gimb_mul.sv]
`timescale 1ns / 1ps
// gimb_mul: shared multiplier, product register then result register (rounded and saturated, or reciprocal-scaled)
module gimb_mul (
  input  logic                               clk,
  input  logic                               go,
  input  gimb_pkg::mul_req_t                 req,
  output logic signed [gimb_pkg::WORD_W-1:0] res
);
  import gimb_pkg::*;

  localparam logic signed [PROD_W-1:0] RND_BIAS = PROD_W'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [PROD_W-1:0] P_SAT_MAX = PROD_W'(SAT_MAX);
  localparam logic signed [PROD_W-1:0] P_SAT_MIN = PROD_W'(SAT_MIN);

  logic signed [PROD_W-1:0] prod;
  logic                     recip;
  logic signed [PROD_W-1:0] rounded;
  logic signed [WORD_W-1:0] q_sat;

  always_ff @(posedge clk) begin
    if (go) begin
      prod  <= req.a * req.b;
      recip <= req.recip;
    end
  end

  // round to nearest, ties up, then saturate to a word
  always_comb begin
    rounded = (prod + RND_BIAS) >>> FRAC_BITS;
    if (rounded > P_SAT_MAX) begin
      q_sat = SAT_MAX;
    end else if (rounded < P_SAT_MIN) begin
      q_sat = SAT_MIN;
    end else begin
      q_sat = WORD_W'(rounded);
    end
  end

  always_ff @(posedge clk) begin
    res <= recip ? WORD_W'(prod >>> RECIP_SHIFT) : q_sat;
  end

endmodule

[rtl/core/two_axis_gimbal_cascaded_pid.sv]
`timescale 1ns / 1ps
// two_axis_gimbal_cascaded_pid: top level, sequencer and per-axis state of the gimbal controller
//
// One sensor word per control tick (accel tilt and gyro rate for roll and pitch, Q16) gives
// one result word: both servo pulse widths in whole us (500..2500), both drives after the
// +-0.2 deadband and +-50 clamp, and both complementary-filtered angles. Each axis runs
// offset removal, gyro scale by 1/131, the complementary filter, an outer angle P+I loop
// and an inner rate P+I loop with a smoothed derivative on the measurement. All products go
// through one shared multiplier (product register, then result register); a small sequencer
// issues eleven products per axis, the axes one after the other. When the work on a sensor
// word ends, its result word turns valid and the sensor channel is ready again in that same
// cycle; no new sensor word is taken while one is in progress.
// The result sits in an output register; the next sensor word is accepted while it waits,
// but the block holds at the end of that word's work until the previous result is taken.
// Register writes are taken at any time and apply to the next sensor word; they must not
// arrive while a word is in progress.
module two_axis_gimbal_cascaded_pid (
  input  logic        clk,
  input  logic        rst,
  gimb_in_if.sink     sensor,
  gimb_cfg_if.sink    cfg,
  gimb_out_if.source  result
);
  import gimb_pkg::*;

  // sequencer steps, one axis pass; each *_MUL issues, each *_DONE uses the product
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] ST_G_MUL    = 5'd0;
  localparam logic [STEP_W-1:0] ST_G_DONE   = 5'd1;
  localparam logic [STEP_W-1:0] ST_F1_MUL   = 5'd2;
  localparam logic [STEP_W-1:0] ST_F1_DONE  = 5'd3;
  localparam logic [STEP_W-1:0] ST_F2_MUL   = 5'd4;
  localparam logic [STEP_W-1:0] ST_F2_DONE  = 5'd5;
  localparam logic [STEP_W-1:0] ST_F3_MUL   = 5'd6;
  localparam logic [STEP_W-1:0] ST_F3_DONE  = 5'd7;
  localparam logic [STEP_W-1:0] ST_EA_MUL   = 5'd8;
  localparam logic [STEP_W-1:0] ST_EA_DONE  = 5'd9;
  localparam logic [STEP_W-1:0] ST_AI_MUL   = 5'd10;
  localparam logic [STEP_W-1:0] ST_AI_DONE  = 5'd11;
  localparam logic [STEP_W-1:0] ST_RI_MUL   = 5'd12;
  localparam logic [STEP_W-1:0] ST_RI_DONE  = 5'd13;
  localparam logic [STEP_W-1:0] ST_DR_MUL   = 5'd14;
  localparam logic [STEP_W-1:0] ST_DR_DONE  = 5'd15;
  localparam logic [STEP_W-1:0] ST_DS1_MUL  = 5'd16;
  localparam logic [STEP_W-1:0] ST_DS1_DONE = 5'd17;
  localparam logic [STEP_W-1:0] ST_DS2_MUL  = 5'd18;
  localparam logic [STEP_W-1:0] ST_DS2_DONE = 5'd19;
  localparam logic [STEP_W-1:0] ST_P_MUL    = 5'd20;
  localparam logic [STEP_W-1:0] ST_P_DONE   = 5'd21;
  localparam logic [STEP_W-1:0] ST_DRIVE    = 5'd22;
  localparam logic [STEP_W-1:0] ST_SERVO    = 5'd23;
  localparam logic [STEP_W-1:0] ST_EMIT     = 5'd24;

  // limits at sum width
  localparam logic signed [SUM_W-1:0] S_SAT_MAX   = SUM_W'(SAT_MAX);
  localparam logic signed [SUM_W-1:0] S_SAT_MIN   = SUM_W'(SAT_MIN);
  localparam logic signed [SUM_W-1:0] S_FUSED_HI  = SUM_W'(LIM_FUSED_HI);
  localparam logic signed [SUM_W-1:0] S_FUSED_LO  = SUM_W'(LIM_FUSED_LO);
  localparam logic signed [SUM_W-1:0] S_ANGLE_I   = SUM_W'(LIM_ANGLE_I);
  localparam logic signed [SUM_W-1:0] S_RATE_I    = SUM_W'(LIM_RATE_I);
  localparam logic signed [SUM_W-1:0] S_DRIVE     = SUM_W'(LIM_DRIVE);
  localparam logic signed [SUM_W-1:0] S_DEADBAND  = SUM_W'(K_DEADBAND);
  localparam int                      SV_W        = SERVO_W + 2;
  localparam logic signed [SV_W-1:0]  SV_MIN      = SV_W'(SERVO_MIN);
  localparam logic signed [SV_W-1:0]  SV_MAX      = SV_W'(SERVO_MAX);

  function automatic logic signed [WORD_W-1:0] clamp_sum(
    input logic signed [SUM_W-1:0] v,
    input logic signed [SUM_W-1:0] lo,
    input logic signed [SUM_W-1:0] hi
  );
    logic signed [SUM_W-1:0] c;
    if (v < lo) begin
      c = lo;
    end else if (v > hi) begin
      c = hi;
    end else begin
      c = v;
    end
    return WORD_W'(c);
  endfunction

  cfg_regs_t regs;

  gimb_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // control
  logic              busy;
  logic              ax;        // 0 roll, 1 pitch
  logic [STEP_W-1:0] step;
  logic              lat_wait;  // product not yet in the result register
  logic              res_valid;
  logic              emit;      // result word loaded at this edge

  // latched sensor word
  logic signed [ACCEL_W-1:0] accel [2];
  logic signed [GYRO_W-1:0]  gyro  [2];

  // per-axis state
  logic signed [WORD_W-1:0]  filt     [2];
  logic signed [RATE_W-1:0]  last_rate[2];
  logic signed [WORD_W-1:0]  ang_int  [2];
  logic signed [WORD_W-1:0]  rate_int [2];
  logic signed [WORD_W-1:0]  dterm    [2];
  logic [SERVO_W-1:0]        servo    [2];
  logic signed [DRV_W-1:0]   drv      [2];

  // working registers of one axis pass
  logic signed [RATE_W-1:0]  g;
  logic signed [AOFS_W-1:0]  aofs;
  logic signed [WORD_W-1:0]  t;
  logic signed [WORD_W-1:0]  u;
  logic signed [WORD_W-1:0]  ea;
  logic signed [WORD_W-1:0]  er;
  logic signed [SUM_W-1:0]   dsum;

  // multiplier
  mul_req_t                 mul_req;
  logic                     mul_go;
  logic signed [WORD_W-1:0] mul_res;

  gimb_mul u_mul (
    .clk (clk),
    .go  (mul_go),
    .req (mul_req),
    .res (mul_res)
  );

  // per-axis selections and small helpers
  logic                       in_ok;
  logic                       gyro_neg;
  logic signed [GYRO_W:0]     gyro_ext;
  logic signed [GYRO_W:0]     gyro_mag;
  logic signed [GYRO_W:0]     gyro_n;
  logic signed [RATE_W:0]     rate_sum;
  logic signed [RATE_W:0]     rate_diff;
  logic signed [WORD_W-1:0]   ea_comb;
  logic signed [TARGET_W-1:0] cur_target;
  logic signed [AOFS_W-1:0]   cur_ofs;
  logic signed [RATE_W-1:0]   g_mag;
  logic signed [DRV_W-1:0]    drive_comb;
  logic signed [SV_W-1:0]     sv_sum;
  logic [SERVO_W-1:0]         servo_comb;

  assign in_ok         = sensor.valid && sensor.ready;
  assign sensor.ready  = !busy;
  assign result.valid  = res_valid;
  // last step: load the output register once the previous word is gone or leaves now
  assign emit          = busy && !lat_wait && (step == ST_EMIT) && (!res_valid || result.ready);

  always_comb begin
    cur_target = ax ? regs.pitch_target : regs.roll_target;
    cur_ofs    = ax ? K_PITCH_OFS : K_ROLL_OFS;
    gyro_ext   = (GYRO_W + 1)'(gyro[ax]);
    gyro_neg   = gyro_ext[GYRO_W];
    gyro_mag   = gyro_neg ? -gyro_ext : gyro_ext;
    gyro_n     = gyro_mag + (GYRO_W + 1)'(ROUND_BIAS);
    g_mag      = RATE_W'(mul_res);
    rate_sum   = (RATE_W + 1)'(last_rate[ax]) + (RATE_W + 1)'(g);
    rate_diff  = (RATE_W + 1)'(last_rate[ax]) - (RATE_W + 1)'(g);
    ea_comb    = clamp_sum(SUM_W'(cur_target) - SUM_W'(filt[ax]), S_SAT_MIN, S_SAT_MAX);

    // deadband, then drive clamp
    if (dsum < S_DEADBAND && dsum > -S_DEADBAND) begin
      drive_comb = '0;
    end else if (dsum > S_DRIVE) begin
      drive_comb = DRV_W'(S_DRIVE);
    end else if (dsum < -S_DRIVE) begin
      drive_comb = DRV_W'(-S_DRIVE);
    end else begin
      drive_comb = DRV_W'(dsum);
    end

    // roll adds its drive, pitch subtracts it
    sv_sum = ax ? (SV_W'(servo[ax]) - SV_W'(drv[ax])) : (SV_W'(servo[ax]) + SV_W'(drv[ax]));
    if (sv_sum < SV_MIN) begin
      servo_comb = SERVO_MIN;
    end else if (sv_sum > SV_MAX) begin
      servo_comb = SERVO_MAX;
    end else begin
      servo_comb = SERVO_W'(sv_sum);
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_go        = 1'b0;
    mul_req.recip = 1'b0;
    mul_req.a     = '0;
    mul_req.b     = '0;
    if (busy && !lat_wait) begin
      case (step)
        ST_G_MUL: begin
          mul_go        = 1'b1;
          mul_req.recip = 1'b1;
          mul_req.a     = WORD_W'(gyro_n);
          mul_req.b     = K_RECIP;
        end
        ST_F1_MUL: begin
          mul_go    = 1'b1;
          mul_req.a = WORD_W'(rate_sum);
          mul_req.b = K_002;
        end
        ST_F2_MUL: begin
          mul_go    = 1'b1;
          mul_req.a = t;
          mul_req.b = K_095;
        end
        ST_F3_MUL: begin
          mul_go    = 1'b1;
          mul_req.a = WORD_W'(aofs);
          mul_req.b = K_005;
        end
        ST_EA_MUL: begin
          mul_go    = 1'b1;
          mul_req.a = ea_comb;
          mul_req.b = MUL_B_W'(regs.angle_gain_p);
        end
        ST_AI_MUL: begin
          mul_go    = 1'b1;
          mul_req.a = ea;
          mul_req.b = MUL_B_W'(regs.angle_gain_i_step);
        end
        ST_RI_MUL: begin
          mul_go    = 1'b1;
          mul_req.a = er;
          mul_req.b = MUL_B_W'(regs.rate_gain_i_step);
        end
        ST_DR_MUL: begin
          mul_go    = 1'b1;
          mul_req.a = WORD_W'(rate_diff);
          mul_req.b = MUL_B_W'(regs.rate_gain_d_step);
        end
        ST_DS1_MUL: begin
          mul_go    = 1'b1;
          mul_req.a = dterm[ax];
          mul_req.b = K_090;
        end
        ST_DS2_MUL: begin
          mul_go    = 1'b1;
          mul_req.a = t;
          mul_req.b = K_010;
        end
        ST_P_MUL: begin
          mul_go    = 1'b1;
          mul_req.a = er;
          mul_req.b = MUL_B_W'(regs.rate_gain_p);
        end
        default: ;
      endcase
    end
  end

  // sequencer and state update
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      ax        <= 1'b0;
      step      <= ST_G_MUL;
      lat_wait  <= 1'b0;
      res_valid <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        filt[i]      <= '0;
        last_rate[i] <= '0;
        ang_int[i]   <= '0;
        rate_int[i]  <= '0;
        dterm[i]     <= '0;
        servo[i]     <= SERVO_MID;
        drv[i]       <= '0;
      end
    end else begin
      if (emit) begin
        res_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        res_valid <= 1'b0;
      end
      if (in_ok) begin
        busy     <= 1'b1;
        ax       <= 1'b0;
        step     <= ST_G_MUL;
        lat_wait <= 1'b0;
        accel[0] <= sensor.accel_roll_angle;
        accel[1] <= sensor.accel_pitch_angle;
        gyro[0]  <= sensor.gyro_roll_rate;
        gyro[1]  <= sensor.gyro_pitch_rate;
      end else if (busy) begin
        if (lat_wait) begin
          lat_wait <= 1'b0;
        end else begin
          if (mul_go) begin
            lat_wait <= 1'b1;
            step     <= step + STEP_W'(1);
          end
          case (step)
            ST_G_DONE: begin
              g    <= gyro_neg ? -g_mag : g_mag;
              aofs <= AOFS_W'(accel[ax]) - cur_ofs;
              step <= ST_F1_MUL;
            end
            ST_F1_DONE: begin
              t    <= clamp_sum(SUM_W'(filt[ax]) + SUM_W'(mul_res), S_SAT_MIN, S_SAT_MAX);
              step <= ST_F2_MUL;
            end
            ST_F2_DONE: begin
              t    <= mul_res;
              step <= ST_F3_MUL;
            end
            ST_F3_DONE: begin
              filt[ax] <= clamp_sum(SUM_W'(t) + SUM_W'(mul_res), S_FUSED_LO, S_FUSED_HI);
              step     <= ST_EA_MUL;
            end
            ST_EA_MUL: begin
              ea <= ea_comb;
            end
            ST_EA_DONE: begin
              er   <= clamp_sum(SUM_W'(mul_res) - SUM_W'(g), S_SAT_MIN, S_SAT_MAX);
              step <= ST_AI_MUL;
            end
            ST_AI_DONE: begin
              ang_int[ax] <= clamp_sum(SUM_W'(ang_int[ax]) + SUM_W'(mul_res),
                                       -S_ANGLE_I, S_ANGLE_I);
              step        <= ST_RI_MUL;
            end
            ST_RI_DONE: begin
              rate_int[ax] <= clamp_sum(SUM_W'(rate_int[ax]) + SUM_W'(mul_res),
                                        -S_RATE_I, S_RATE_I);
              step         <= ST_DR_MUL;
            end
            ST_DR_DONE: begin
              t    <= mul_res;
              step <= ST_DS1_MUL;
            end
            ST_DS1_DONE: begin
              u    <= mul_res;
              step <= ST_DS2_MUL;
            end
            ST_DS2_DONE: begin
              dterm[ax] <= clamp_sum(SUM_W'(u) + SUM_W'(mul_res), S_SAT_MIN, S_SAT_MAX);
              step      <= ST_P_MUL;
            end
            ST_P_DONE: begin
              dsum          <= SUM_W'(mul_res) + SUM_W'(rate_int[ax]) + SUM_W'(ang_int[ax])
                               + SUM_W'(dterm[ax]);
              last_rate[ax] <= g;
              step          <= ST_DRIVE;
            end
            ST_DRIVE: begin
              drv[ax] <= drive_comb;
              step    <= ST_SERVO;
            end
            ST_SERVO: begin
              servo[ax] <= servo_comb;
              if (!ax) begin
                ax   <= 1'b1;
                step <= ST_G_MUL;
              end else begin
                step <= ST_EMIT;
              end
            end
            ST_EMIT: begin
              // wait here while the previous word is still unread
              if (emit) begin
                result.roll_pulse_us     <= servo[0][SERVO_W-1:FRAC_BITS];
                result.pitch_pulse_us    <= servo[1][SERVO_W-1:FRAC_BITS];
                result.roll_drive        <= DRIVE_W'(drv[0]);
                result.pitch_drive       <= DRIVE_W'(drv[1]);
                result.roll_fused_angle  <= FUSED_W'(filt[0]);
                result.pitch_fused_angle <= FUSED_W'(filt[1]);
                busy                     <= 1'b0;
              end
            end
            default: ;  // issue steps, handled above
          endcase
        end
      end
    end
  end

  // checks
  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.roll_pulse_us >= PULSE_MIN && result.roll_pulse_us <= PULSE_MAX
                      && result.pitch_pulse_us >= PULSE_MIN
                      && result.pitch_pulse_us <= PULSE_MAX))
    else $error("servo pulse width out of range");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (DRV_W'(result.roll_drive) <= DRV_W'(LIM_DRIVE)
                      && DRV_W'(result.roll_drive) >= -DRV_W'(LIM_DRIVE)
                      && DRV_W'(result.pitch_drive) <= DRV_W'(LIM_DRIVE)
                      && DRV_W'(result.pitch_drive) >= -DRV_W'(LIM_DRIVE)))
    else $error("drive outside clamp");

  a_start: assert property (@(posedge clk) disable iff (rst)
    (sensor.valid && sensor.ready) |=> (busy && step == ST_G_MUL && !ax && !lat_wait))
    else $error("sensor word accepted without starting the roll pass");

  a_wait_after_issue: assert property (@(posedge clk) disable iff (rst)
    lat_wait |-> ($past(mul_go) && busy))
    else $error("multiplier wait without an issued product");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for the two-axis gimbal controller, predictor and scoreboard inside
module tb_top;
  import gimb_pkg::*;

  // ---------------------------------------------------------------------------------------
  // Fixed point constants of the controller, worked out here from first principles
  // ---------------------------------------------------------------------------------------
  localparam int     FRAC      = 16;
  localparam longint QHALF     = longint'(1) <<< (FRAC - 1);
  localparam longint WORD_HI   = (longint'(1) <<< 31) - 1;
  localparam longint WORD_LO   = -(longint'(1) <<< 31);
  localparam longint Q_095     = ((longint'(95) <<< FRAC) + 50) / 100;
  localparam longint Q_005     = ((longint'(5) <<< FRAC) + 50) / 100;
  localparam longint Q_002     = ((longint'(2) <<< FRAC) + 50) / 100;
  localparam longint Q_090     = ((longint'(90) <<< FRAC) + 50) / 100;
  localparam longint Q_010     = ((longint'(10) <<< FRAC) + 50) / 100;
  localparam longint Q_DEAD    = ((longint'(2) <<< FRAC) + 5) / 10;
  localparam longint OFS_ROLL  = ((longint'(73) <<< FRAC) + 5) / 10;
  localparam longint OFS_PITCH = ((longint'(9) <<< FRAC) + 5) / 10;
  localparam longint CAP_ANG_I = longint'(50) <<< FRAC;
  localparam longint CAP_RAT_I = longint'(30) <<< FRAC;
  localparam longint CAP_DRIVE = longint'(50) <<< FRAC;
  localparam longint CAP_FUSED = longint'(180) <<< FRAC;
  localparam longint SRV_MID   = longint'(1500) <<< FRAC;
  localparam longint SRV_MIN   = longint'(500) <<< FRAC;
  localparam longint SRV_MAX   = longint'(2500) <<< FRAC;
  localparam longint GYRO_DIV  = 131;

  // power-on gains: 2.3, 0.2 and 0.005
  localparam longint INIT_ANGLE_P = ((longint'(23) <<< FRAC) + 5) / 10;
  localparam longint INIT_RATE_P  = ((longint'(2) <<< FRAC) + 5) / 10;
  localparam longint INIT_RATE_D  = ((longint'(5) <<< FRAC) + 500) / 1000;

  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(7);

  // field extremes: legal range and raw bit range
  localparam int ACC_SPAN = 11796480;
  localparam int GYR_SPAN = 131072000;
  localparam int TGT_SPAN = 5898240;
  localparam int GAIN_TOP = 4194304;
  localparam int ACC_TOP  = (1 << (ACCEL_W - 1)) - 1;
  localparam int ACC_BOT  = -(1 << (ACCEL_W - 1));
  localparam int GYR_TOP  = (1 << (GYRO_W - 1)) - 1;
  localparam int GYR_BOT  = -(1 << (GYRO_W - 1));

  localparam int RAND_PHASES = 8;
  localparam int PHASE_WORDS = 50;

  typedef struct {
    logic signed [ACCEL_W-1:0] accel_roll;
    logic signed [ACCEL_W-1:0] accel_pitch;
    logic signed [GYRO_W-1:0]  gyro_roll;
    logic signed [GYRO_W-1:0]  gyro_pitch;
  } sensor_word_t;

  typedef struct {
    logic [PULSE_W-1:0]        roll_pulse;
    logic [PULSE_W-1:0]        pitch_pulse;
    logic signed [DRIVE_W-1:0] roll_drive;
    logic signed [DRIVE_W-1:0] pitch_drive;
    logic signed [FUSED_W-1:0] roll_fused;
    logic signed [FUSED_W-1:0] pitch_fused;
  } result_word_t;

  // per-axis controller state, kept wide so that saturation is explicit
  typedef struct {
    longint fused;
    longint last_rate;
    longint angle_i;
    longint rate_i;
    longint dterm;
    longint servo;
  } axis_state_t;

  // ---------------------------------------------------------------------------------------
  // Scoreboard: own copy of registers and state, predicts one result word per sensor word
  // ---------------------------------------------------------------------------------------
  class gimbal_board;
    axis_state_t  ax [2];
    longint       target [2];
    longint       gain_angle_p, gain_angle_i, gain_rate_p, gain_rate_i, gain_rate_d;
    result_word_t awaited_words [$];
    int           mismatches;
    int           words_checked;

    function new();
      target[0]    = 0;
      target[1]    = 0;
      gain_angle_p = INIT_ANGLE_P;
      gain_angle_i = 0;
      gain_rate_p  = INIT_RATE_P;
      gain_rate_i  = 0;
      gain_rate_d  = INIT_RATE_D;
      mismatches   = 0;
      words_checked = 0;
      for (int k = 0; k < 2; k++) begin
        ax[k] = '{default: 0};
        ax[k].servo = SRV_MID;
      end
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint sat_word(longint v);
      return clip(v, WORD_LO, WORD_HI);
    endfunction

    // Q16 product, round half up, floor shift
    function longint qmul(longint a, longint b);
      return sat_word((a * b + QHALF) >>> FRAC);
    endfunction

    // gyro / 131, nearest, symmetric about zero
    function longint scale_gyro(longint x);
      if (x >= 0) return (x + GYRO_DIV / 2) / GYRO_DIV;
      return -((-x + GYRO_DIV / 2) / GYRO_DIV);
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ROLL_TARGET:  target[0]    = longint'($signed(val));
        REG_PITCH_TARGET: target[1]    = longint'($signed(val));
        REG_ANGLE_GAIN_P: gain_angle_p = longint'(val[GAIN_W-1:0]);
        REG_ANGLE_GAIN_I: gain_angle_i = longint'(val[GAIN_W-1:0]);
        REG_RATE_GAIN_P:  gain_rate_p  = longint'(val[GAIN_W-1:0]);
        REG_RATE_GAIN_I:  gain_rate_i  = longint'(val[GAIN_W-1:0]);
        REG_RATE_GAIN_D:  gain_rate_d  = longint'(val[GAIN_W-1:0]);
        default: ;
      endcase
    endfunction

    // one tick of one axis: filter, outer and inner loop; returns the drive
    function longint advance_axis(int k, longint tgt, longint accel, longint ofs, longint gyro);
      longint g, a, f, ea, tr, er, draw, drv;
      g = scale_gyro(gyro);
      a = sat_word(accel - ofs);
      f = sat_word(ax[k].fused + qmul(sat_word(ax[k].last_rate + g), Q_002));
      f = sat_word(qmul(Q_095, f) + qmul(Q_005, a));
      ax[k].fused = clip(f, -CAP_FUSED, CAP_FUSED);
      ea = sat_word(tgt - ax[k].fused);
      tr = qmul(gain_angle_p, ea);
      ax[k].angle_i = clip(ax[k].angle_i + qmul(gain_angle_i, ea), -CAP_ANG_I, CAP_ANG_I);
      er = sat_word(tr - g);
      ax[k].rate_i = clip(ax[k].rate_i + qmul(gain_rate_i, er), -CAP_RAT_I, CAP_RAT_I);
      draw = qmul(gain_rate_d, sat_word(ax[k].last_rate - g));
      ax[k].dterm = sat_word(qmul(Q_090, ax[k].dterm) + qmul(Q_010, draw));
      drv = qmul(gain_rate_p, er) + ax[k].rate_i + ax[k].angle_i + ax[k].dterm;
      ax[k].last_rate = g;
      if (drv < Q_DEAD && drv > -Q_DEAD) drv = 0;
      return clip(drv, -CAP_DRIVE, CAP_DRIVE);
    endfunction

    function void take_sensor_word(sensor_word_t w);
      longint       rd, pd;
      result_word_t e;
      rd = advance_axis(0, target[0], longint'(w.accel_roll), OFS_ROLL, longint'(w.gyro_roll));
      pd = advance_axis(1, target[1], longint'(w.accel_pitch), OFS_PITCH,
                        longint'(w.gyro_pitch));
      // roll drive adds to its servo, pitch drive subtracts
      ax[0].servo   = clip(ax[0].servo + rd, SRV_MIN, SRV_MAX);
      ax[1].servo   = clip(ax[1].servo - pd, SRV_MIN, SRV_MAX);
      e.roll_pulse  = PULSE_W'(ax[0].servo >>> FRAC);
      e.pitch_pulse = PULSE_W'(ax[1].servo >>> FRAC);
      e.roll_drive  = DRIVE_W'(rd);
      e.pitch_drive = DRIVE_W'(pd);
      e.roll_fused  = FUSED_W'(ax[0].fused);
      e.pitch_fused = FUSED_W'(ax[1].fused);
      awaited_words.push_back(e);
    endfunction

    task log_mismatch(string msg);
      if (mismatches < 40) $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task match_result_word(result_word_t got);
      result_word_t e;
      if (awaited_words.size() == 0) begin
        log_mismatch("result word with nothing awaited");
        return;
      end
      e = awaited_words.pop_front();
      words_checked++;
      if (got.roll_pulse !== e.roll_pulse)
        log_mismatch($sformatf("roll_pulse_us got %0d want %0d", got.roll_pulse, e.roll_pulse));
      if (got.pitch_pulse !== e.pitch_pulse)
        log_mismatch($sformatf("pitch_pulse_us got %0d want %0d", got.pitch_pulse,
                               e.pitch_pulse));
      if (got.roll_drive !== e.roll_drive)
        log_mismatch($sformatf("roll_drive got %0d want %0d", got.roll_drive, e.roll_drive));
      if (got.pitch_drive !== e.pitch_drive)
        log_mismatch($sformatf("pitch_drive got %0d want %0d", got.pitch_drive, e.pitch_drive));
      if (got.roll_fused !== e.roll_fused)
        log_mismatch($sformatf("roll_fused_angle got %0d want %0d", got.roll_fused,
                               e.roll_fused));
      if (got.pitch_fused !== e.pitch_fused)
        log_mismatch($sformatf("pitch_fused_angle got %0d want %0d", got.pitch_fused,
                               e.pitch_fused));
    endtask
  endclass

  // ---------------------------------------------------------------------------------------
  // Clock, channels, block
  // ---------------------------------------------------------------------------------------
  logic clk;
  logic rst;

  gimb_in_if  sensor_ch ();
  gimb_cfg_if cfg_ch ();
  gimb_out_if result_ch ();

  two_axis_gimbal_cascaded_pid dut (
    .clk    (clk),
    .rst    (rst),
    .sensor (sensor_ch),
    .cfg    (cfg_ch),
    .result (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  gimbal_board board;

  // idle odds in percent per cycle, set per stretch of the run
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int words_sent    = 0;
  int reg_writes    = 0;
  int settings_run  = 1;

  // random run generator state: a base word held for a while with jitter on top
  int run_left = 0;
  int run_kind = 0;
  int base_ar, base_ap, base_gr, base_gp;
  int jit_a, jit_g;

  // ---------------------------------------------------------------------------------------
  // Word builders
  // ---------------------------------------------------------------------------------------
  function automatic sensor_word_t make_word(int ar, int ap, int gr, int gp);
    sensor_word_t w;
    w.accel_roll  = ACCEL_W'(ar);
    w.accel_pitch = ACCEL_W'(ap);
    w.gyro_roll   = GYRO_W'(gr);
    w.gyro_pitch  = GYRO_W'(gp);
    return w;
  endfunction

  function automatic int rand_span(int half);
    return int'($urandom_range(2 * half)) - half;
  endfunction

  function automatic int pick_edge(int width, int span);
    case ($urandom_range(4))
      0:       return (1 << (width - 1)) - 1;
      1:       return -(1 << (width - 1));
      2:       return span;
      3:       return -span;
      default: return 0;
    endcase
  endfunction

  // Runs of related words so the filter, integrators and servos can wind up; some runs are
  // plain bit noise, some settle on the setpoint so drives pass through the deadband.
  function automatic sensor_word_t next_random_word();
    if (run_left == 0) begin
      run_kind = $urandom_range(9);
      run_left = $urandom_range(1, 40);
      case (run_kind)
        0, 1: run_left = $urandom_range(1, 6);
        2, 3: begin
          base_ar = int'(board.target[0] + OFS_ROLL);
          base_ap = int'(board.target[1] + OFS_PITCH);
          base_gr = 0;
          base_gp = 0;
          jit_a   = 13107;
          jit_g   = 2 << FRAC;
        end
        4: begin
          base_ar = pick_edge(ACCEL_W, ACC_SPAN);
          base_ap = pick_edge(ACCEL_W, ACC_SPAN);
          base_gr = pick_edge(GYRO_W, GYR_SPAN);
          base_gp = pick_edge(GYRO_W, GYR_SPAN);
          jit_a   = 0;
          jit_g   = 0;
        end
        default: begin
          base_ar = rand_span(ACC_SPAN);
          base_ap = rand_span(ACC_SPAN);
          base_gr = rand_span(GYR_SPAN);
          base_gp = rand_span(GYR_SPAN);
          jit_a   = $urandom_range(0, 2 << FRAC);
          jit_g   = $urandom_range(0, 200 << FRAC);
        end
      endcase
    end
    run_left--;
    if (run_kind < 2) return make_word($urandom, $urandom, $urandom, $urandom);
    return make_word(base_ar + rand_span(jit_a), base_ap + rand_span(jit_a),
                     base_gr + rand_span(jit_g), base_gp + rand_span(jit_g));
  endfunction

  // ---------------------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------------------
  // valid stays high between back-to-back words; it only drops for a gap or a drain
  task automatic send_word(input sensor_word_t w);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      sensor_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    sensor_ch.valid             <= 1'b1;
    sensor_ch.accel_roll_angle  <= w.accel_roll;
    sensor_ch.accel_pitch_angle <= w.accel_pitch;
    sensor_ch.gyro_roll_rate    <= w.gyro_roll;
    sensor_ch.gyro_pitch_rate   <= w.gyro_pitch;
    do @(posedge clk); while (!sensor_ch.ready);
    board.take_sensor_word(w);
    words_sent++;
  endtask

  // stop sending and wait until every awaited result word is back
  task automatic drain();
    sensor_ch.valid <= 1'b0;
    do @(posedge clk); while (board.awaited_words.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    board.set_register(idx, val);
    reg_writes++;
  endtask

  // Register settings: typical, the legal top, raw extremes with all gains off, raw top
  // with the spare data bit set, then random ones. Every setting also pokes the unused index.
  task automatic load_setting(input int k);
    logic [CFG_DATA_W-1:0] rt, pt, ap, ai, rp, ri, rdv;
    case (k)
      0: begin
        rt = CFG_DATA_W'(rand_span(TGT_SPAN)); pt = CFG_DATA_W'(rand_span(TGT_SPAN));
        ap = CFG_DATA_W'(INIT_ANGLE_P); ai = CFG_DATA_W'(3277);
        rp = CFG_DATA_W'(INIT_RATE_P);  ri = CFG_DATA_W'(1311); rdv = CFG_DATA_W'(INIT_RATE_D);
      end
      1: begin
        rt = CFG_DATA_W'(TGT_SPAN); pt = CFG_DATA_W'(-TGT_SPAN);
        ap = CFG_DATA_W'(GAIN_TOP); ai = CFG_DATA_W'(GAIN_TOP);
        rp = CFG_DATA_W'(GAIN_TOP); ri = CFG_DATA_W'(GAIN_TOP); rdv = CFG_DATA_W'(GAIN_TOP);
      end
      2: begin
        // gains off: only the held integrators and the decaying D term reach the drive
        rt = {1'b0, {(CFG_DATA_W-1){1'b1}}}; pt = {1'b1, {(CFG_DATA_W-1){1'b0}}};
        ap = '0; ai = '0; rp = '0; ri = '0; rdv = '0;
      end
      3: begin
        rt = CFG_DATA_W'($urandom); pt = CFG_DATA_W'($urandom);
        ap = '1; ai = '1; rp = '1; ri = '1; rdv = '1;
      end
      7: begin
        rt = CFG_DATA_W'($urandom); pt = CFG_DATA_W'($urandom);
        ap = CFG_DATA_W'($urandom); ai = CFG_DATA_W'($urandom);
        rp = CFG_DATA_W'($urandom); ri = CFG_DATA_W'($urandom); rdv = CFG_DATA_W'($urandom);
      end
      default: begin
        rt  = CFG_DATA_W'(rand_span(TGT_SPAN)); pt = CFG_DATA_W'(rand_span(TGT_SPAN));
        ap  = CFG_DATA_W'($urandom_range(0, 4 << FRAC));
        ai  = CFG_DATA_W'($urandom_range(0, 16384));
        rp  = CFG_DATA_W'($urandom_range(0, 1 << FRAC));
        ri  = CFG_DATA_W'($urandom_range(0, 8192));
        rdv = CFG_DATA_W'($urandom_range(0, 1 << FRAC));
      end
    endcase
    write_reg(REG_ROLL_TARGET, rt);
    write_reg(REG_PITCH_TARGET, pt);
    write_reg(REG_ANGLE_GAIN_P, ap);
    write_reg(REG_ANGLE_GAIN_I, ai);
    write_reg(REG_RATE_GAIN_P, rp);
    write_reg(REG_RATE_GAIN_I, ri);
    write_reg(REG_RATE_GAIN_D, rdv);
    write_reg(REG_NONE, CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
    settings_run++;
  endtask

  // 0: slow sender, very slow receiver; 1: the other way round; 2: no idling at all
  task automatic set_regime(input int r);
    case (r)
      0:       begin send_idle_pct = 35; recv_idle_pct = 86; end
      1:       begin send_idle_pct = 86; recv_idle_pct = 35; end
      default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
    endcase
  endtask

  // ---------------------------------------------------------------------------------------
  // Result side: random back-pressure and checking of every accepted word
  // ---------------------------------------------------------------------------------------
  initial begin : result_sink
    result_word_t got;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        got.roll_pulse  = result_ch.roll_pulse_us;
        got.pitch_pulse = result_ch.pitch_pulse_us;
        got.roll_drive  = result_ch.roll_drive;
        got.pitch_drive = result_ch.pitch_drive;
        got.roll_fused  = result_ch.roll_fused_angle;
        got.pitch_fused = result_ch.pitch_fused_angle;
        board.match_result_word(got);
      end
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    board = new();
    rst                         <= 1'b1;
    sensor_ch.valid             <= 1'b0;
    sensor_ch.accel_roll_angle  <= '0;
    sensor_ch.accel_pitch_angle <= '0;
    sensor_ch.gyro_roll_rate    <= '0;
    sensor_ch.gyro_pitch_rate   <= '0;
    cfg_ch.valid                <= 1'b0;
    cfg_ch.index                <= '0;
    cfg_ch.data                 <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed words under power-on registers: zero, legal ends, raw bit ends, offsets that
    // cancel, then a long push at the raw ends towards the fused limit and the servo stops
    set_regime(0);
    send_word(make_word(0, 0, 0, 0));
    send_word(make_word(ACC_SPAN, ACC_SPAN, GYR_SPAN, GYR_SPAN));
    send_word(make_word(-ACC_SPAN, -ACC_SPAN, -GYR_SPAN, -GYR_SPAN));
    send_word(make_word(ACC_TOP, ACC_BOT, GYR_TOP, GYR_BOT));
    send_word(make_word(ACC_BOT, ACC_TOP, GYR_BOT, GYR_TOP));
    send_word(make_word(int'(OFS_ROLL), int'(OFS_PITCH), 0, 0));
    repeat (19) send_word(make_word(ACC_TOP, ACC_BOT, GYR_TOP, GYR_BOT));

    // random part, one register setting per phase; idle pattern moves across the phases
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      load_setting(ph);
      set_regime((ph < 3) ? 0 : ((ph < 6) ? 1 : 2));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // mid-phase hold-off until the block has handed back everything
        if (n == PHASE_WORDS / 2) drain();
        send_word(next_random_word());
      end
    end

    drain();
    repeat (150) @(posedge clk);
    if (board.awaited_words.size() != 0)
      board.log_mismatch($sformatf("%0d result words never arrived",
                                   board.awaited_words.size()));

    $display("Sent %0d sensor words under %0d register settings (%0d register writes)",
             words_sent, settings_run, reg_writes);
    $display("Checked %0d result words, %0d mismatches", board.words_checked,
             board.mismatches);
    if (board.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/gimb_pkg.sv
rtl/core/gimb_if.sv
rtl/core/gimb_cfg_regs.sv
rtl/core/gimb_mul.sv
rtl/core/two_axis_gimbal_cascaded_pid.sv
verif/tb_top.sv
